[design/bsc_pkg.sv]
package bsc_pkg;

  localparam int COORD_W   = 11;
  localparam int COLOR_W   = 8;
  localparam int SUM_W     = 33;
  localparam int CNT_W     = 23;
  localparam int CFG_IDX_W = 2;

  // Saturation point of the hit counter; keeps both sums inside SUM_W bits.
  localparam logic [CNT_W-1:0] HIT_CAP = CNT_W'(4194304);

  localparam logic [COLOR_W-1:0] RED_THR_RESET   = COLOR_W'(253);
  localparam logic [COLOR_W-1:0] GREEN_THR_RESET = COLOR_W'(150);
  localparam logic [COLOR_W-1:0] BLUE_THR_RESET  = COLOR_W'(150);

  localparam int unsigned DEF_MAX_WIDTH   = 2048;
  localparam int unsigned DEF_MAX_HEIGHT  = 2048;
  localparam int unsigned DEF_QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_THR   = 2'd0,
    REG_GREEN_THR = 2'd1,
    REG_BLUE_THR  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] centroid_x;
    logic [COORD_W-1:0] centroid_y;
    logic [CNT_W-1:0]   dot_count;
    logic               dot_found;
  } result_t;

  // Accumulated totals of one finished frame.
  typedef struct packed {
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0] hit_count;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[design/bright_spot_centroid.sv]
// Bright spot centroid: finds the center of a laser dot in an RGB pixel stream.
//
// Input queue side: drive a pixel (position, color, last_pixel mark) with push;
// the pixel transfers on a rising edge with push high and full low. Pixels are
// taken one per cycle for the whole frame; full rises only when the frame
// queue between the accumulator and the divider holds QUEUE_DEPTH finished
// frames, and then only blocks further pixels until the divider drains one.
// Result queue side: one result per frame, present while empty is low and
// transferred on a rising edge with pop high and empty low. A stalled result
// holds; the divider keeps it until it is popped, while pixels keep flowing.
// Path: the frame record of the last pixel enters the frame queue, is loaded
// into the divider, runs 11 restoring steps of the shared-cycle divider, and
// the result is then registered. The divider takes a new frame only after the
// last result is registered; frames arriving sooner back up into the queue.
// Configuration: cfg_index 0/1/2 writes the red/green/blue threshold; writes
// complete at once (cfg_ready is always high); unknown indexes are dropped.
// Reset: thresholds return to 253/150/150, sums and count clear, both queues
// empty.
module bright_spot_centroid
  import bsc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = DEF_MAX_HEIGHT,
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  pixel_t               pixel,
  output logic                 empty,
  input  logic                 pop,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data
);

  logic          accept;
  logic          frame_push;
  frame_t        frame_in;
  frame_t        frame_out;
  logic          q_pop;
  queue_status_t q_status;

  // Registers take a write in any cycle.
  assign cfg_ready = 1'b1;

  // Hold off pixels only while the frame queue cannot take another record.
  assign full   = q_status.full;
  assign accept = push && !full;

  bsc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .pixel      (pixel),
    .frame_push (frame_push),
    .frame      (frame_in)
  );

  bsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (frame_push),
    .wdata  (frame_in),
    .pop    (q_pop),
    .rdata  (frame_out),
    .status (q_status)
  );

  bsc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_status.empty),
    .frame   (frame_out),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  // A result without a dot carries all-zero fields.
  a_no_dot_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.dot_found) |->
      (result.centroid_x == '0 && result.centroid_y == '0 && result.dot_count == '0))
    else $error("empty frame result has nonzero fields");

  // A found dot always has a nonzero, unsaturated-beyond-cap count.
  a_found_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.dot_found) |->
      (result.dot_count != '0 && result.dot_count <= HIT_CAP))
    else $error("found dot with bad count");

  // Frame queue cannot be full and empty at once.
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !q_status.empty)
    else $error("frame queue status inconsistent");

  // A frame record is never pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    frame_push |-> !q_status.full)
    else $error("frame record pushed into full queue");

endmodule

[design/bsc_front.sv]
module bsc_front
  import bsc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data,
  input  logic                 accept,
  input  pixel_t               pixel,
  output logic                 frame_push,
  output frame_t               frame
);

  logic [COLOR_W-1:0] red_thr;
  logic [COLOR_W-1:0] green_thr;
  logic [COLOR_W-1:0] blue_thr;
  logic [SUM_W-1:0]   sum_x;
  logic [SUM_W-1:0]   sum_y;
  logic [CNT_W-1:0]   hit_count;
  logic [SUM_W-1:0]   sum_x_next;
  logic [SUM_W-1:0]   sum_y_next;
  logic [CNT_W-1:0]   hit_count_next;
  logic               in_frame;
  logic               hit;

  assign in_frame = (32'(pixel.pixel_x) < MAX_WIDTH) && (32'(pixel.pixel_y) < MAX_HEIGHT);
  assign hit = in_frame && (pixel.red > red_thr) && (pixel.green > green_thr) &&
               (pixel.blue > blue_thr) && (hit_count < HIT_CAP);

  always_comb begin
    sum_x_next     = sum_x;
    sum_y_next     = sum_y;
    hit_count_next = hit_count;
    if (hit) begin
      sum_x_next     = sum_x + SUM_W'(pixel.pixel_x);
      sum_y_next     = sum_y + SUM_W'(pixel.pixel_y);
      hit_count_next = hit_count + CNT_W'(1);
    end
  end

  // The frame record includes the last pixel itself.
  assign frame_push      = accept && pixel.last_pixel;
  assign frame.sum_x     = sum_x_next;
  assign frame.sum_y     = sum_y_next;
  assign frame.hit_count = hit_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_thr   <= RED_THR_RESET;
      green_thr <= GREEN_THR_RESET;
      blue_thr  <= BLUE_THR_RESET;
      sum_x     <= '0;
      sum_y     <= '0;
      hit_count <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_RED_THR:   red_thr   <= cfg_data;
          REG_GREEN_THR: green_thr <= cfg_data;
          REG_BLUE_THR:  blue_thr  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (pixel.last_pixel) begin
          sum_x     <= '0;
          sum_y     <= '0;
          hit_count <= '0;
        end else begin
          sum_x     <= sum_x_next;
          sum_y     <= sum_y_next;
          hit_count <= hit_count_next;
        end
      end
    end
  end

endmodule

[design/bsc_queue.sv]
module bsc_queue
  import bsc_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  frame_t        wdata,
  input  logic          pop,
  output frame_t        rdata,
  output queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W_Q-1:0] FULL_CNT = CNT_W_Q'(DEPTH);

  frame_t              entries [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W_Q-1:0]  count;
  logic                do_push;
  logic                do_pop;

  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rdata        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W_Q'(1);
        2'b01:   count <= count - CNT_W_Q'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[design/bsc_back.sv]
module bsc_back
  import bsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  frame_t  frame,
  output logic    q_pop,
  input  logic    pop,
  output logic    empty,
  output result_t result
);

  localparam int STEP_W = $clog2(COORD_W);
  localparam int DS_W   = CNT_W + COORD_W;
  localparam logic [STEP_W-1:0] FIRST_STEP = STEP_W'(COORD_W - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_HOLD
  } state_t;

  state_t             state;
  logic [SUM_W-1:0]   rem_x;
  logic [SUM_W-1:0]   rem_y;
  logic [DS_W-1:0]    div_sh;
  logic [COORD_W-1:0] quo_x;
  logic [COORD_W-1:0] quo_y;
  logic [CNT_W-1:0]   count;
  logic [STEP_W-1:0]  step;
  logic               res_valid;
  logic               ge_x;
  logic               ge_y;
  logic [DS_W-1:0]    diff_x;
  logic [DS_W-1:0]    diff_y;

  assign q_pop = (state == S_IDLE) && !q_empty;
  assign empty = !res_valid;

  // One restoring step per cycle on both coordinates; the mean is below 2^COORD_W.
  assign diff_x = DS_W'(rem_x) - div_sh;
  assign diff_y = DS_W'(rem_y) - div_sh;
  assign ge_x   = DS_W'(rem_x) >= div_sh;
  assign ge_y   = DS_W'(rem_y) >= div_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // In S_HOLD the result register is refilled in place, so clear only elsewhere.
      if (pop && res_valid && (state != S_HOLD)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            rem_x  <= frame.sum_x;
            rem_y  <= frame.sum_y;
            div_sh <= DS_W'(frame.hit_count) << (COORD_W - 1);
            count  <= frame.hit_count;
            step   <= FIRST_STEP;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (ge_x) begin
            rem_x <= diff_x[SUM_W-1:0];
          end
          if (ge_y) begin
            rem_y <= diff_y[SUM_W-1:0];
          end
          quo_x  <= {quo_x[COORD_W-2:0], ge_x};
          quo_y  <= {quo_y[COORD_W-2:0], ge_y};
          div_sh <= div_sh >> 1;
          step   <= step - STEP_W'(1);
          if (step == '0) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (!res_valid || pop) begin
            if (count == '0) begin
              result <= '0;
            end else begin
              result.centroid_x <= quo_x;
              result.centroid_y <= quo_y;
              result.dot_count  <= count;
              result.dot_found  <= 1'b1;
            end
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[bench/testbench.sv]
module testbench
  import bsc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Pixels per random phase, and cycles to let the divider finish after the
  // last expected centroid has come out.
  localparam int unsigned PHASE_PIXELS  = 110;
  localparam int unsigned PHASE_COUNT   = 8;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned LOUD_ERRORS   = 10;
  localparam int unsigned PROBE_ROWS    = 18;

  // Index that maps to no threshold register; a write to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(3);

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  pixel_t               pixel_in;
  logic                 empty;
  logic                 pop;
  result_t              result_out;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_data;

  bright_spot_centroid u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pixel     (pixel_in),
    .empty     (empty),
    .pop       (pop),
    .result    (result_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the block: thresholds plus the running frame totals.
  logic [COLOR_W-1:0] thr_red;
  logic [COLOR_W-1:0] thr_green;
  logic [COLOR_W-1:0] thr_blue;
  logic [SUM_W-1:0]   acc_x;
  logic [SUM_W-1:0]   acc_y;
  logic [CNT_W-1:0]   acc_hits;

  // Centroids the block still owes us, oldest first.
  result_t pending_centroids[$];

  int unsigned bad_results   = 0;
  int unsigned pixels_sent   = 0;
  int unsigned lit_frames    = 0;
  int unsigned dark_frames   = 0;
  int unsigned settings_used = 0;
  bit          steady_tail   = 1'b0;

  // Directed probes, taken under the reset thresholds (253/150/150). Rows with
  // 'typed' set carry a centroid that is obvious by inspection; the rest are
  // checked against the shadow model.
  typedef struct packed {
    pixel_t  px;
    logic    typed;
    result_t want;
  } probe_row_t;

  probe_row_t probe_rows [0:PROBE_ROWS-1] = '{
    // dark single-pixel frame: nothing found, all zero
    '{'{11'd0, 11'd0, 8'd0, 8'd0, 8'd0, 1'b1}, 1'b1, '{11'd0, 11'd0, 23'd0, 1'b0}},
    // brightest pixel at both far corners
    '{'{11'd2047, 11'd2047, 8'd255, 8'd255, 8'd255, 1'b1}, 1'b1,
      '{11'd2047, 11'd2047, 23'd1, 1'b1}},
    '{'{11'd0, 11'd0, 8'd255, 8'd255, 8'd255, 1'b1}, 1'b1,
      '{11'd0, 11'd0, 23'd1, 1'b1}},
    // each color exactly at its threshold is not a hit
    '{'{11'd7, 11'd7, 8'd253, 8'd255, 8'd255, 1'b1}, 1'b1, '{11'd0, 11'd0, 23'd0, 1'b0}},
    '{'{11'd7, 11'd7, 8'd255, 8'd150, 8'd255, 1'b1}, 1'b1, '{11'd0, 11'd0, 23'd0, 1'b0}},
    '{'{11'd7, 11'd7, 8'd255, 8'd255, 8'd150, 1'b1}, 1'b1, '{11'd0, 11'd0, 23'd0, 1'b0}},
    // one step above every threshold is a hit
    '{'{11'd5, 11'd9, 8'd254, 8'd151, 8'd151, 1'b1}, 1'b1, '{11'd5, 11'd9, 23'd1, 1'b1}},
    // alternating bit patterns on the coordinates
    '{'{11'd1365, 11'd682, 8'd255, 8'd255, 8'd255, 1'b1}, 1'b1,
      '{11'd1365, 11'd682, 23'd1, 1'b1}},
    '{'{11'd682, 11'd1365, 8'd255, 8'd170, 8'd170, 1'b1}, 1'b1,
      '{11'd682, 11'd1365, 23'd1, 1'b1}},
    // multi-pixel frame with a miss inside; mean truncates
    '{'{11'd10, 11'd20, 8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
    '{'{11'd11, 11'd21, 8'd254, 8'd200, 8'd160, 1'b0}, 1'b0, '0},
    '{'{11'd2047, 11'd0, 8'd100, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
    '{'{11'd2047, 11'd0, 8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
    '{'{11'd3, 11'd2047, 8'd255, 8'd255, 8'd255, 1'b1}, 1'b0, '0},
    // frame that ends on a miss still reports the earlier hit
    '{'{11'd100, 11'd200, 8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
    '{'{11'd0, 11'd0, 8'd10, 8'd10, 8'd10, 1'b1}, 1'b1, '{11'd100, 11'd200, 23'd1, 1'b1}},
    // two-pixel frame of misses
    '{'{11'd2047, 11'd2047, 8'd0, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
    '{'{11'd2047, 11'd2047, 8'd255, 8'd0, 8'd255, 1'b1}, 1'b1,
      '{11'd0, 11'd0, 23'd0, 1'b0}}
  };

  // Advance the shadow frame totals by one pixel; return 1 and the centroid
  // when the pixel closes a frame.
  function automatic bit accumulate_pixel(input pixel_t p, output result_t c);
    logic       on_frame;
    logic       is_dot;
    logic [SUM_W-1:0] qx;
    logic [SUM_W-1:0] qy;
    on_frame = (p.pixel_x < DEF_MAX_WIDTH) && (p.pixel_y < DEF_MAX_HEIGHT);
    is_dot = on_frame && (p.red > thr_red) && (p.green > thr_green) &&
             (p.blue > thr_blue);
    // Saturate the count so the sums can never wrap.
    if (is_dot && acc_hits < HIT_CAP) begin
      acc_x = acc_x + SUM_W'(p.pixel_x);
      acc_y = acc_y + SUM_W'(p.pixel_y);
      acc_hits = acc_hits + CNT_W'(1);
    end
    c = '0;
    if (!p.last_pixel) begin
      return 1'b0;
    end
    if (acc_hits != '0) begin
      qx = acc_x / SUM_W'(acc_hits);
      qy = acc_y / SUM_W'(acc_hits);
      c.centroid_x = qx[COORD_W-1:0];
      c.centroid_y = qy[COORD_W-1:0];
      c.dot_count  = acc_hits;
      c.dot_found  = 1'b1;
    end
    acc_x = '0;
    acc_y = '0;
    acc_hits = '0;
    return 1'b1;
  endfunction

  // Compare one popped centroid with the oldest one owed.
  task automatic check_centroid(input result_t got);
    result_t want;
    if (pending_centroids.size() == 0) begin
      bad_results++;
      if (bad_results <= LOUD_ERRORS) begin
        $display("tb: unexpected centroid x=%0d y=%0d count=%0d found=%0b",
                 got.centroid_x, got.centroid_y, got.dot_count, got.dot_found);
      end
      return;
    end
    want = pending_centroids.pop_front();
    if (got.centroid_x !== want.centroid_x || got.centroid_y !== want.centroid_y ||
        got.dot_count !== want.dot_count || got.dot_found !== want.dot_found) begin
      bad_results++;
      if (bad_results <= LOUD_ERRORS) begin
        $display("tb: centroid mismatch exp x=%0d y=%0d count=%0d found=%0b",
                 want.centroid_x, want.centroid_y, want.dot_count, want.dot_found);
        $display("tb:                   got x=%0d y=%0d count=%0d found=%0b",
                 got.centroid_x, got.centroid_y, got.dot_count, got.dot_found);
      end
    end
  endtask

  // Offer one pixel and hold it until it transfers. Leave push high so the
  // next pixel can follow back to back.
  task automatic send_pixel(input pixel_t p, input logic typed, input result_t want);
    result_t c;
    push <= 1'b1;
    pixel_in <= p;
    do @(posedge clk); while (full);
    pixels_sent++;
    if (accumulate_pixel(p, c)) begin
      if (c.dot_found) lit_frames++;
      else dark_frames++;
      pending_centroids.push_back(typed ? want : c);
    end
  endtask

  task automatic hold_push(input int unsigned cycles);
    push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop push, wait for every owed centroid, then let the divider go quiet.
  task automatic drain_block();
    push <= 1'b0;
    while (pending_centroids.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leave cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RED_THR:   thr_red   = val;
      REG_GREEN_THR: thr_green = val;
      REG_BLUE_THR:  thr_blue  = val;
      default: ;
    endcase
  endtask

  // Bias colors toward the threshold: at it, just above it, or well above, with some fully random values.
  function automatic logic [COLOR_W-1:0] pick_color(input logic [COLOR_W-1:0] thr);
    case ($urandom_range(0, 7))
      0, 1:    return COLOR_W'($urandom_range(0, 255));
      2:       return thr;
      3:       return (thr == 8'd255) ? thr : thr + COLOR_W'(1);
      default: return (thr == 8'd255) ? thr : COLOR_W'($urandom_range(thr + 1, 255));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    if ($urandom_range(0, 5) == 0) begin
      return $urandom_range(0, 1) ? 11'd2047 : 11'd0;
    end
    return COORD_W'($urandom_range(0, 2047));
  endfunction

  // One frame of random pixels; gap_odds of 0 means send back to back.
  task automatic send_frame(input int unsigned len, input int unsigned gap_odds);
    pixel_t p;
    for (int unsigned i = 0; i < len; i++) begin
      p.pixel_x    = pick_coord();
      p.pixel_y    = pick_coord();
      p.red        = pick_color(thr_red);
      p.green      = pick_color(thr_green);
      p.blue       = pick_color(thr_blue);
      p.last_pixel = (i == len - 1);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        hold_push($urandom_range(1, 18));
      end
      send_pixel(p, 1'b0, '0);
    end
  endtask

  // Result side: pop with random stall bursts until the quiet tail.
  initial begin : centroid_sink
    int unsigned stall_left;
    stall_left = 0;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) check_centroid(result_out);
      if (stall_left != 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (!steady_tail && $urandom_range(1, 8) == 1) stall_left = $urandom_range(1, 18);
      end
    end
  end

  // Watchdog: end the run if nothing transfers on any port for too long.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: no transfer for %0d cycles, %0d centroids still owed",
               STALL_LIMIT, pending_centroids.size());
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : pixel_source
    int unsigned gap_odds;
    int unsigned phase_start;
    int unsigned len;
    probe_row_t  row;

    rst       = 1'b1;
    push      = 1'b0;
    pixel_in  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    thr_red   = RED_THR_RESET;
    thr_green = GREEN_THR_RESET;
    thr_blue  = BLUE_THR_RESET;
    acc_x     = '0;
    acc_y     = '0;
    acc_hits  = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed probes under the reset thresholds.
    settings_used++;
    for (int unsigned i = 0; i < PROBE_ROWS; i++) begin
      row = probe_rows[i];
      send_pixel(row.px, row.typed, row.want);
    end
    // Hold the source until every probe centroid is back.
    drain_block();

    // Random phases, each under its own threshold setting. Thresholds only
    // change with the block drained.
    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_RED_THR, 8'd0);
          write_reg(REG_GREEN_THR, 8'd0);
          write_reg(REG_BLUE_THR, 8'd0);
        end
        1: begin
          // nothing can exceed 255: every frame comes back empty
          write_reg(REG_RED_THR, 8'd255);
          write_reg(REG_GREEN_THR, 8'd255);
          write_reg(REG_BLUE_THR, 8'd255);
        end
        2: begin
          // the stray write of zero would open a gate wide if it landed
          write_reg(REG_RED_THR, 8'd254);
          write_reg(REG_GREEN_THR, 8'd254);
          write_reg(REG_BLUE_THR, 8'd254);
          write_reg(REG_NONE, 8'd0);
        end
        default: begin
          write_reg(REG_RED_THR, COLOR_W'($urandom_range(0, 255)));
          write_reg(REG_GREEN_THR, COLOR_W'($urandom_range(0, 255)));
          write_reg(REG_BLUE_THR, COLOR_W'($urandom_range(0, 255)));
        end
      endcase
      cfg_valid <= 1'b0;
      settings_used++;

      // Run the final phase with no idling on either side.
      if (phase == PHASE_COUNT - 1) steady_tail = 1'b1;
      gap_odds = steady_tail ? 0 : ($urandom_range(0, 1) ? 5 : 25);

      phase_start = pixels_sent;
      while (pixels_sent - phase_start < PHASE_PIXELS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
        send_frame(len, gap_odds);
      end
      drain_block();
    end

    $display("tb: %0d pixels in %0d frames (%0d with a dot, %0d without)",
             pixels_sent, lit_frames + dark_frames, lit_frames, dark_frames);
    $display("tb: %0d threshold settings, including all-zero and all-255",
             settings_used);
    if (bad_results == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
